// File: rtl/ldf_pkg.sv
// ----------------------------------------------------------------------------
// ldf_pkg: shared types and constants of the line and payload deframer
// Holds the result layout, the line class and parse phase codes, the
// prefix characters and the default sizes of the line and cover stores.
// ----------------------------------------------------------------------------
`default_nettype none

package ldf_pkg;

  // Default store sizes
  localparam int unsigned COVER_CAPACITY_DEF = 16384;
  localparam int unsigned LINE_CAPACITY_DEF  = 512;

  // Result field widths
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned INDEX_W = 14;
  localparam int unsigned LEN_W   = 15;
  localparam int unsigned NUM_W   = 32;

  // Characters of interest
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_VT    = 8'h0B;
  localparam logic [7:0] CHR_FF    = 8'h0C;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_S     = 8'h53;
  localparam logic [7:0] CHR_A     = 8'h41;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_TEXT     = 2'd0,
    KIND_LINE_END = 2'd1,
    KIND_PAYLOAD  = 2'd2
  } kind_e;

  // Line class, one-hot
  typedef enum logic [3:0] {
    CLS_PEND  = 4'b0001,
    CLS_STATE = 4'b0010,
    CLS_ART   = 4'b0100,
    CLS_OTHER = 4'b1000
  } line_class_e;

  // Number parse phase, one-hot
  typedef enum logic [3:0] {
    PH_BLANK = 4'b0001,
    PH_SIGN  = 4'b0010,
    PH_DIGIT = 4'b0100,
    PH_DONE  = 4'b1000
  } num_phase_e;

  // Header number parse state
  typedef struct packed {
    num_phase_e         phase;
    logic               negative;
    logic               over;
    logic [NUM_W-1:0]   accum;
  } num_t;

  // One result word
  typedef struct packed {
    kind_e              kind;
    logic [DATA_W-1:0]  data;
    logic               kept;
    logic [INDEX_W-1:0] byte_index;
    logic               last;
    logic [LEN_W-1:0]   cover_length;
  } res_t;

  // Characters of the "ART:" prefix by position
  function automatic logic [7:0] art_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h41;
      2'd1:    c = 8'h52;
      2'd2:    c = 8'h54;
      2'd3:    c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Characters of the "ST " prefix by position
  function automatic logic [7:0] st_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h53;
      2'd1:    c = 8'h54;
      2'd2:    c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ldf_stream_if.sv
// ----------------------------------------------------------------------------
// ldf_stream_if: valid/ready channels of the deframer
// ldf_in_if carries received bytes, ldf_out_if carries result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface ldf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ldf_out_if;
  logic                           valid;
  logic                           ready;
  logic [ldf_pkg::KIND_W-1:0]     kind;
  logic [ldf_pkg::DATA_W-1:0]     data;
  logic                           kept;
  logic [ldf_pkg::INDEX_W-1:0]    byte_index;
  logic                           last;
  logic [ldf_pkg::LEN_W-1:0]      cover_length;

  modport source (output valid, output kind, output data, output kept,
                  output byte_index, output last, output cover_length,
                  input ready);
  modport sink   (input valid, input kind, input data, input kept,
                  input byte_index, input last, input cover_length,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/ldf_num_parse.sv
// ----------------------------------------------------------------------------
// ldf_num_parse: one step of the header length parser
// Skips leading blanks, takes one sign, then folds in decimal digits and
// saturates the value once it leaves 32 bits. Any other byte ends the parse.
// ----------------------------------------------------------------------------
`default_nettype none

module ldf_num_parse (
  input  wire logic [7:0]    rx_byte_i,
  input  ldf_pkg::num_t      num_i,
  output ldf_pkg::num_t      num_o
);

  logic                          is_digit;
  logic                          is_blank;
  logic                          is_sign;
  logic [3:0]                    digit;
  logic [ldf_pkg::NUM_W+3:0]     acc_ext;
  logic [ldf_pkg::NUM_W+3:0]     prod;

  assign is_digit = (rx_byte_i >= ldf_pkg::CHR_ZERO) && (rx_byte_i <= ldf_pkg::CHR_NINE);
  assign is_blank = (rx_byte_i == ldf_pkg::CHR_SPACE) || (rx_byte_i == ldf_pkg::CHR_TAB) ||
                    (rx_byte_i == ldf_pkg::CHR_VT)    || (rx_byte_i == ldf_pkg::CHR_FF) ||
                    (rx_byte_i == ldf_pkg::CHR_LF)    || (rx_byte_i == ldf_pkg::CHR_CR);
  assign is_sign  = (rx_byte_i == ldf_pkg::CHR_PLUS) || (rx_byte_i == ldf_pkg::CHR_MINUS);
  assign digit    = 4'(rx_byte_i - ldf_pkg::CHR_ZERO);

  // accum * 10 + digit as shifts and adds
  assign acc_ext = {4'b0, num_i.accum};
  assign prod    = (acc_ext << 3) + (acc_ext << 1) + {{(ldf_pkg::NUM_W){1'b0}}, digit};

  always_comb begin
    num_o = num_i;
    if (num_i.phase != ldf_pkg::PH_DONE) begin
      if ((num_i.phase == ldf_pkg::PH_BLANK) && is_blank) begin
        num_o = num_i;
      end else if ((num_i.phase == ldf_pkg::PH_BLANK) && is_sign) begin
        num_o.negative = (rx_byte_i == ldf_pkg::CHR_MINUS);
        num_o.phase    = ldf_pkg::PH_SIGN;
      end else if (!is_digit) begin
        num_o.phase = ldf_pkg::PH_DONE;
      end else begin
        num_o.phase = ldf_pkg::PH_DIGIT;
        // Saturate once the value leaves 32 bits
        if (!num_i.over) begin
          if (prod[ldf_pkg::NUM_W+3:ldf_pkg::NUM_W] != 4'b0) begin
            num_o.over  = 1'b1;
            num_o.accum = '1;
          end else begin
            num_o.accum = prod[ldf_pkg::NUM_W-1:0];
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/ldf_core.sv
// ----------------------------------------------------------------------------
// ldf_core: deframer state and per-byte result logic
// Tracks text/binary mode, line fill, prefix class and header parse, and
// forms at most one result word for each byte it is stepped with.
// ----------------------------------------------------------------------------
`default_nettype none

module ldf_core #(
  parameter int unsigned COVER_CAPACITY = ldf_pkg::COVER_CAPACITY_DEF,
  parameter int unsigned LINE_CAPACITY  = ldf_pkg::LINE_CAPACITY_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic [7:0]    rx_byte_i,
  output ldf_pkg::res_t      res_o,
  output logic               res_vld_o
);

  localparam int unsigned FILL_W = $clog2(LINE_CAPACITY);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(LINE_CAPACITY - 1);
  localparam logic [ldf_pkg::NUM_W-1:0] CAP_W = ldf_pkg::NUM_W'(COVER_CAPACITY);

  logic                          mode_q, mode_d;
  logic [FILL_W-1:0]             fill_q, fill_d;
  ldf_pkg::line_class_e          cls_q, cls_d;
  logic                          art_q, art_d;
  ldf_pkg::num_t                 num_q, num_d, num_nxt;
  logic [ldf_pkg::NUM_W-1:0]     exp_q, exp_d;
  logic [ldf_pkg::NUM_W-1:0]     recv_q, recv_d;
  logic [ldf_pkg::NUM_W-1:0]     hdr_val;
  logic [ldf_pkg::NUM_W-1:0]     kept_len;
  logic                          kept;
  logic                          last;

  ldf_num_parse u_num_parse (
    .rx_byte_i (rx_byte_i),
    .num_i     (num_q),
    .num_o     (num_nxt)
  );

  // Header value as it stands at line end
  always_comb begin
    if (num_q.over) begin
      hdr_val = '1;
    end else if (num_q.negative) begin
      hdr_val = '0 - num_q.accum;
    end else begin
      hdr_val = num_q.accum;
    end
  end

  // Payload position checks
  assign kept     = recv_q < CAP_W;
  assign last     = (recv_q + 1'b1) >= exp_q;
  assign kept_len = (exp_q <= CAP_W) ? exp_q : CAP_W;

  // Advance the state for one byte and form its result
  always_comb begin
    mode_d    = mode_q;
    fill_d    = fill_q;
    cls_d     = cls_q;
    art_d     = art_q;
    num_d     = num_q;
    exp_d     = exp_q;
    recv_d    = recv_q;
    res_o     = '0;
    res_vld_o = 1'b0;
    if (step_i) begin
      if (mode_q) begin
        recv_d                = recv_q + 1'b1;
        res_vld_o             = 1'b1;
        res_o.kind            = ldf_pkg::KIND_PAYLOAD;
        res_o.data            = rx_byte_i;
        res_o.kept            = kept;
        res_o.byte_index      = kept ? recv_q[ldf_pkg::INDEX_W-1:0] : '0;
        res_o.last            = last;
        if (last) begin
          mode_d             = 1'b0;
          res_o.cover_length = kept_len[ldf_pkg::LEN_W-1:0];
        end
      end else if (rx_byte_i == ldf_pkg::CHR_CR) begin
        // drop carriage returns
      end else if (rx_byte_i == ldf_pkg::CHR_LF) begin
        if (cls_q == ldf_pkg::CLS_ART) begin
          exp_d  = hdr_val;
          recv_d = '0;
          if (hdr_val != '0) begin
            mode_d = 1'b1;
          end
        end
        if (cls_q == ldf_pkg::CLS_STATE) begin
          res_vld_o  = 1'b1;
          res_o.kind = ldf_pkg::KIND_LINE_END;
        end
        fill_d         = '0;
        cls_d          = ldf_pkg::CLS_PEND;
        art_d          = 1'b0;
        num_d.phase    = ldf_pkg::PH_BLANK;
        num_d.negative = 1'b0;
        num_d.over     = 1'b0;
        num_d.accum    = '0;
      end else if (fill_q != FILL_MAX) begin
        fill_d = fill_q + 1'b1;
        case (cls_q)
          ldf_pkg::CLS_PEND: begin
            if (fill_q == '0) begin
              if (rx_byte_i == ldf_pkg::CHR_S) begin
                art_d = 1'b0;
              end else if (rx_byte_i == ldf_pkg::CHR_A) begin
                art_d = 1'b1;
              end else begin
                cls_d = ldf_pkg::CLS_OTHER;
              end
            end else if (art_q) begin
              if ((fill_q > FILL_W'(3)) || (rx_byte_i != ldf_pkg::art_char(fill_q[1:0]))) begin
                cls_d = ldf_pkg::CLS_OTHER;
              end else if (fill_q == FILL_W'(3)) begin
                cls_d       = ldf_pkg::CLS_ART;
                num_d.phase = ldf_pkg::PH_BLANK;
              end
            end else begin
              if ((fill_q > FILL_W'(2)) || (rx_byte_i != ldf_pkg::st_char(fill_q[1:0]))) begin
                cls_d = ldf_pkg::CLS_OTHER;
              end else if (fill_q == FILL_W'(2)) begin
                cls_d       = ldf_pkg::CLS_STATE;
                num_d.phase = ldf_pkg::PH_BLANK;
              end
            end
          end
          ldf_pkg::CLS_STATE: begin
            // A zero byte ends the text of the line
            if (num_q.phase != ldf_pkg::PH_DONE) begin
              if (rx_byte_i == ldf_pkg::CHR_NUL) begin
                num_d.phase = ldf_pkg::PH_DONE;
              end else begin
                res_vld_o  = 1'b1;
                res_o.kind = ldf_pkg::KIND_TEXT;
                res_o.data = rx_byte_i;
              end
            end
          end
          ldf_pkg::CLS_ART: begin
            num_d = num_nxt;
          end
          default: begin
            // ignore other lines
          end
        endcase
      end
    end
  end

  // Hold the deframer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= 1'b0;
      fill_q         <= '0;
      cls_q          <= ldf_pkg::CLS_PEND;
      art_q          <= 1'b0;
      num_q.phase    <= ldf_pkg::PH_BLANK;
      num_q.negative <= 1'b0;
      num_q.over     <= 1'b0;
      num_q.accum    <= '0;
      exp_q          <= '0;
      recv_q         <= '0;
    end else begin
      mode_q <= mode_d;
      fill_q <= fill_d;
      cls_q  <= cls_d;
      art_q  <= art_d;
      num_q  <= num_d;
      exp_q  <= exp_d;
      recv_q <= recv_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/line_and_binary_payload_deframer_unit.sv
// ----------------------------------------------------------------------------
// line_and_binary_payload_deframer_unit: text line and payload deframer
// Usage:
//   in_i carries one received byte per word. out_o carries result words:
//   state-line text bytes, state-line ends and cover payload bytes, the
//   last payload byte tagged with the kept cover length.
//   A byte is taken into an input register, processed by the
//   line/header/payload logic once the output register is free or being
//   emptied and, if it yields a result, written to the output register,
//   which drives out_o.valid. One byte per cycle is sustained while
//   out_o.ready does not stall the output register.
//   Bytes that yield no result (carriage returns, prefixes, header text,
//   ignored lines) are consumed without an output word.
//   When out_o.ready is low with a result waiting, the input register
//   still takes one more byte; after that in_i.ready drops until the
//   result is taken. Nothing is dropped or repeated under stalls.
//   Reset returns the block to text mode with an empty line and clears
//   the payload length and count; both registers come up empty.
// ----------------------------------------------------------------------------
`default_nettype none

module line_and_binary_payload_deframer_unit #(
  parameter int unsigned COVER_CAPACITY = ldf_pkg::COVER_CAPACITY_DEF,
  parameter int unsigned LINE_CAPACITY  = ldf_pkg::LINE_CAPACITY_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ldf_in_if.sink     in_i,
  ldf_out_if.source  out_o
);

  logic           in_vld_q;
  logic [7:0]     rx_q;
  logic           out_vld_q;
  ldf_pkg::res_t  res_q;
  ldf_pkg::res_t  res;
  logic           res_vld;
  logic           adv;
  logic           step;

  // Output register is free or being emptied this cycle
  assign adv        = !out_vld_q || out_o.ready;
  assign step       = in_vld_q && adv;
  assign in_i.ready = !in_vld_q || adv;

  ldf_core #(
    .COVER_CAPACITY (COVER_CAPACITY),
    .LINE_CAPACITY  (LINE_CAPACITY)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (rx_q),
    .res_o     (res),
    .res_vld_o (res_vld)
  );

  // Input register: load on accept, empty when processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      rx_q <= in_i.rx_byte;
    end
  end

  // Output register: advance when free or taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= step && res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_vld) begin
      res_q <= res;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.kind         = res_q.kind;
  assign out_o.data         = res_q.data;
  assign out_o.kept         = res_q.kept;
  assign out_o.byte_index   = res_q.byte_index;
  assign out_o.last         = res_q.last;
  assign out_o.cover_length = res_q.cover_length;

endmodule

`default_nettype wire
